### src/zsw_pkg.sv
// ----------------------------------------------------------------------------
// zsw_pkg: shared types and constants of the zlib stored-stream writer
// Job descriptor passed from the front end to the byte serializer, step
// codes of the serializer and stream format constants.
// ----------------------------------------------------------------------------
`default_nettype none

package zsw_pkg;

	// Stream format constants.
	localparam int unsigned LEN_W     = 30;
	localparam int unsigned BLOCK_W   = 16;
	localparam logic [BLOCK_W-1:0] BLOCK_MAX = 16'd65535;
	localparam logic [16:0] ADLER_MOD = 17'd65521;
	localparam logic [7:0]  ZLIB_CMF  = 8'h78;
	localparam logic [7:0]  ZLIB_FLG  = 8'h01;

	// Configuration port.
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic [0:0]  REG_STREAM_LENGTH = 1'b0;

	// Queue between front end and serializer.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Serializer step codes, in emission order.
	localparam int unsigned STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_ZHDR0    = 4'd0;
	localparam logic [STEP_W-1:0] STEP_ZHDR1    = 4'd1;
	localparam logic [STEP_W-1:0] STEP_BFINAL   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_LEN_LO   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_LEN_HI   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_NLEN_LO  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_NLEN_HI  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_DATA     = 4'd7;
	localparam logic [STEP_W-1:0] STEP_ADH_HI   = 4'd8;
	localparam logic [STEP_W-1:0] STEP_ADH_LO   = 4'd9;
	localparam logic [STEP_W-1:0] STEP_ADL_HI   = 4'd10;
	localparam logic [STEP_W-1:0] STEP_ADL_LO   = 4'd11;

	// One input item, classified: which bytes it causes and their contents.
	typedef struct packed {
		logic               zhdr;      // stream header precedes the data
		logic               bhdr;      // block header precedes the data
		logic               bfinal;    // block is the last one of the stream
		logic [BLOCK_W-1:0] blk_len;   // LEN of the block
		logic [7:0]         data;      // the raw byte
		logic               trailer;   // Adler-32 follows the data
		logic [15:0]        adler_hi;
		logic [15:0]        adler_lo;
	} job_t;

endpackage : zsw_pkg

`default_nettype wire

### src/zsw_front.sv
// ----------------------------------------------------------------------------
// zsw_front: input front end
// Accepts raw bytes, tracks stream and block position and the running
// Adler-32, and turns each item into a job descriptor for the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module zsw_front import zsw_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       data_byte,
	input  wire logic [LEN_W-1:0] stream_length,
	input  wire logic             q_full,
	output logic                  q_push,
	output job_t                  q_job
);

	logic               started_q;
	logic [LEN_W-1:0]   bytes_left_q;
	logic [BLOCK_W-1:0] block_left_q;
	logic [15:0]        adler_lo_q;
	logic [15:0]        adler_hi_q;

	logic [LEN_W-1:0]   bytes_eff;
	logic [BLOCK_W-1:0] block_eff;
	logic [15:0]        lo_eff;
	logic [15:0]        hi_eff;
	logic               need_blk;
	logic               fits;
	logic [BLOCK_W-1:0] size;
	logic [BLOCK_W-1:0] block_next;
	logic [LEN_W-1:0]   bytes_next;
	logic [16:0]        lo_sum;
	logic [16:0]        hi_sum;
	logic [15:0]        lo_next;
	logic [15:0]        hi_next;
	logic               last_byte;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// State as seen by this item: a new stream starts from fresh values.
	always_comb begin
		if (!started_q) begin
			bytes_eff = (stream_length == '0) ? LEN_W'(1) : stream_length;
			block_eff = '0;
			lo_eff    = 16'd1;
			hi_eff    = 16'd0;
		end else begin
			bytes_eff = bytes_left_q;
			block_eff = block_left_q;
			lo_eff    = adler_lo_q;
			hi_eff    = adler_hi_q;
		end
	end

	// Block sizing and position counters.
	always_comb begin
		need_blk   = (block_eff == '0);
		fits       = (bytes_eff <= LEN_W'(BLOCK_MAX));
		size       = fits ? bytes_eff[BLOCK_W-1:0] : BLOCK_MAX;
		block_next = (need_blk ? size : block_eff) - BLOCK_W'(1);
		bytes_next = bytes_eff - LEN_W'(1);
		last_byte  = (bytes_next == '0);
	end

	// Adler-32 update with conditional subtraction.
	always_comb begin
		lo_sum  = {1'b0, lo_eff} + {9'b0, data_byte};
		lo_next = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
		hi_sum  = {1'b0, hi_eff} + {1'b0, lo_next};
		hi_next = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
	end

	// Job descriptor for this item.
	always_comb begin
		q_job.zhdr     = !started_q;
		q_job.bhdr     = need_blk;
		q_job.bfinal   = fits;
		q_job.blk_len  = size;
		q_job.data     = data_byte;
		q_job.trailer  = last_byte;
		q_job.adler_hi = hi_next;
		q_job.adler_lo = lo_next;
	end

	// Stream state; the stream re-arms after its last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			bytes_left_q <= '0;
			block_left_q <= '0;
			adler_lo_q   <= 16'd1;
			adler_hi_q   <= 16'd0;
		end else if (q_push) begin
			bytes_left_q <= bytes_next;
			if (last_byte) begin
				started_q    <= 1'b0;
				block_left_q <= '0;
				adler_lo_q   <= 16'd1;
				adler_hi_q   <= 16'd0;
			end else begin
				started_q    <= 1'b1;
				block_left_q <= block_next;
				adler_lo_q   <= lo_next;
				adler_hi_q   <= hi_next;
			end
		end
	end

endmodule : zsw_front

`default_nettype wire

### src/zsw_queue.sv
// ----------------------------------------------------------------------------
// zsw_queue: job queue
// Small flip-flop FIFO of job descriptors between the front end and the
// serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module zsw_queue import zsw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output logic      not_empty,
	output job_t      head_job
);

	job_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_job  = slots_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

endmodule : zsw_queue

`default_nettype wire

### src/zsw_back.sv
// ----------------------------------------------------------------------------
// zsw_back: byte serializer
// Takes job descriptors from the queue and emits their bytes one per cycle
// through an output register while out_stall does not hold it.
// ----------------------------------------------------------------------------
`default_nettype none

module zsw_back import zsw_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_not_empty,
	input  wire job_t  q_job,
	output logic       q_pop,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       stream_end
);

	job_t              job_q;
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              run_last_q;
	logic              stream_end_q;

	logic              adv;
	logic              cur_last;
	logic              load;
	logic [STEP_W-1:0] first_step;
	logic [STEP_W-1:0] next_step;
	logic [7:0]        cur_byte;

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_last   = run_last_q;
	assign stream_end = stream_end_q;

	// Advance when the output register is free or being drained.
	always_comb begin
		adv      = busy_q && (!out_valid_q || !out_stall);
		cur_last = (step_q == STEP_ADL_LO) || ((step_q == STEP_DATA) && !job_q.trailer);
		load     = q_not_empty && (!busy_q || (adv && cur_last));
		q_pop    = load;
	end

	// Step sequencing: skip the headers and trailer that a job lacks.
	always_comb begin
		if (q_job.zhdr) begin
			first_step = STEP_ZHDR0;
		end else if (q_job.bhdr) begin
			first_step = STEP_BFINAL;
		end else begin
			first_step = STEP_DATA;
		end

		if (step_q == STEP_ZHDR1) begin
			next_step = job_q.bhdr ? STEP_BFINAL : STEP_DATA;
		end else begin
			next_step = step_q + STEP_W'(1);
		end
	end

	// Byte for the current step.
	always_comb begin
		case (step_q)
			STEP_ZHDR0:   cur_byte = ZLIB_CMF;
			STEP_ZHDR1:   cur_byte = ZLIB_FLG;
			STEP_BFINAL:  cur_byte = {7'b0, job_q.bfinal};
			STEP_LEN_LO:  cur_byte = job_q.blk_len[7:0];
			STEP_LEN_HI:  cur_byte = job_q.blk_len[15:8];
			STEP_NLEN_LO: cur_byte = ~job_q.blk_len[7:0];
			STEP_NLEN_HI: cur_byte = ~job_q.blk_len[15:8];
			STEP_DATA:    cur_byte = job_q.data;
			STEP_ADH_HI:  cur_byte = job_q.adler_hi[15:8];
			STEP_ADH_LO:  cur_byte = job_q.adler_hi[7:0];
			STEP_ADL_HI:  cur_byte = job_q.adler_lo[15:8];
			STEP_ADL_LO:  cur_byte = job_q.adler_lo[7:0];
			default:      cur_byte = 8'h00;
		endcase
	end

	// Current job and step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_ZHDR0;
		end else if (load) begin
			busy_q <= 1'b1;
			step_q <= first_step;
		end else if (adv) begin
			if (cur_last) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= next_step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= q_job;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q   <= cur_byte;
			run_last_q   <= cur_last;
			stream_end_q <= (step_q == STEP_ADL_LO);
		end
	end

endmodule : zsw_back

`default_nettype wire

### src/zlib_stored_stream_writer.sv
// ----------------------------------------------------------------------------
// zlib_stored_stream_writer: zlib stream of stored deflate blocks
// Wraps a raw byte stream of configured length into a zlib stream: header,
// stored blocks of up to 65535 bytes each with LEN/NLEN, Adler-32 trailer.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------
//   input    | in        | in_valid/in_stall  | data_byte
//   output   | out       | out_valid/out_stall| out_byte, run_last, stream_end
//   config   | in        | APB psel/penable   | stream_length at address 0
//
// One input byte is accepted per cycle while the job queue has room; it
// goes through a queue slot, the job register and the output register.
// The serializer emits one byte per cycle unless stalled, so an item with
// headers or the trailer yields up to 12 bytes; the queue absorbs the excess.
// Reset is asynchronous; no clearing pass is needed. Output stalls hold the
// output register and back up into the queue, then into in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module zlib_stored_stream_writer import zsw_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            data_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 out_byte,
	output logic                       run_last,
	output logic                       stream_end
);

	logic [LEN_W-1:0] stream_length_q;
	logic             reg_sel;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_not_empty;
	job_t             push_job;
	job_t             head_job;

	// Configuration register.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1] == REG_STREAM_LENGTH);
	assign prdata  = reg_sel ? APB_DATA_W'(stream_length_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_length_q <= LEN_W'(1);
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			stream_length_q <= pwdata[LEN_W-1:0];
		end
	end

	zsw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.stream_length (stream_length_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_job         (push_job)
	);

	zsw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_job  (head_job)
	);

	zsw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_job       (head_job),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.stream_end  (stream_end)
	);

endmodule : zlib_stored_stream_writer

`default_nettype wire
